FILE: sv/sopr_pkg.sv
package sopr_pkg;

	localparam int NUM_W      = 16;
	localparam int MAP_W      = 17;
	localparam int SIDE_W     = 9;
	localparam int LAYOUT_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int TOTAL_W    = 2 * SIDE_W;
	localparam int MAX_SIDE   = 256;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEP;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS,
		CFG_COLS,
		CFG_SRC,
		CFG_DST
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_ALL,
		KIND_EVEN,
		KIND_ODD
	} line_kind_t;

	typedef struct packed {
		logic [NUM_W-1:0] offset;
		logic             oor;
	} div_req_t;

	typedef struct packed {
		logic [NUM_W-1:0]  quo;
		logic [SIDE_W-1:0] rem;
		logic              oor;
	} div_res_t;

	function automatic line_kind_t layout_kind(input logic [LAYOUT_W-1:0] layout);
		line_kind_t kind;
		unique case (layout)
			4'd0, 4'd3, 4'd8, 4'd11:   kind = KIND_PLAIN;
			4'd1, 4'd2, 4'd9, 4'd10:   kind = KIND_ALL;
			4'd4, 4'd7, 4'd12, 4'd14:  kind = KIND_EVEN;
			4'd5, 4'd6, 4'd13, 4'd15:  kind = KIND_ODD;
		endcase
		return kind;
	endfunction

	// Layouts with the second code bit set run in fully reversed order.
	function automatic logic layout_reversed(input logic [LAYOUT_W-1:0] layout);
		return layout[1];
	endfunction

	function automatic logic layout_col_major(input logic [LAYOUT_W-1:0] layout);
		return layout[LAYOUT_W-1];
	endfunction

	// Line parity is that of the 0-based line index.
	function automatic logic line_flipped(input line_kind_t kind, input logic line_lsb);
		logic flipped;
		unique case (kind)
			KIND_PLAIN: flipped = 1'b0;
			KIND_ALL:   flipped = 1'b1;
			KIND_EVEN:  flipped = line_lsb;
			KIND_ODD:   flipped = !line_lsb;
		endcase
		return flipped;
	endfunction

	function automatic logic [SIDE_W-1:0] mirror(input logic [SIDE_W-1:0] side,
			input logic [SIDE_W-1:0] idx);
		return side - SIDE_W'(1) - idx;
	endfunction

endpackage

FILE: sv/sopr_divider.sv
module sopr_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sopr_pkg::div_req_t               in_req,
	input  logic [sopr_pkg::SIDE_W-1:0]      divisor,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sopr_pkg::div_res_t               out_res
);

	localparam int STAGES = sopr_pkg::DIV_STAGES;
	localparam int LAST   = STAGES - 1;
	localparam int NW     = sopr_pkg::NUM_W;
	localparam int SW     = sopr_pkg::SIDE_W;

	logic          valid_s [STAGES];
	logic [NW-1:0] work_s  [STAGES];
	logic [SW-1:0] rem_s   [STAGES];
	logic          oor_s   [STAGES];

	logic          vin     [STAGES];
	logic [NW-1:0] work_in [STAGES];
	logic [SW-1:0] rem_in  [STAGES];
	logic          oor_in  [STAGES];
	logic [NW-1:0] work_nx [STAGES];
	logic [SW-1:0] rem_nx  [STAGES];
	logic          ready   [STAGES+1];

	assign ready[STAGES] = out_ready;

	// Restoring division: work holds the dividend bits still to be consumed at the
	// top and the quotient bits already produced at the bottom.
	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign vin[k]     = in_valid;
			assign work_in[k] = in_req.offset;
			assign rem_in[k]  = '0;
			assign oor_in[k]  = in_req.oor;
		end else begin : g_next
			assign vin[k]     = valid_s[k-1];
			assign work_in[k] = work_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign oor_in[k]  = oor_s[k-1];
		end

		assign ready[k] = !valid_s[k] || ready[k+1];

		always_comb begin
			logic [SW:0]   trial;
			logic [NW-1:0] w;
			logic [SW-1:0] r;
			w = work_in[k];
			r = rem_in[k];
			for (int i = 0; i < sopr_pkg::DIV_STEP; i++) begin
				trial = {r, w[NW-1]};
				if (trial >= {1'b0, divisor}) begin
					trial = trial - {1'b0, divisor};
					w = {w[NW-2:0], 1'b1};
				end else begin
					w = {w[NW-2:0], 1'b0};
				end
				r = trial[SW-1:0];
			end
			work_nx[k] = w;
			rem_nx[k]  = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (ready[k]) begin
				valid_s[k] <= vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ready[k] && vin[k]) begin
				work_s[k] <= work_nx[k];
				rem_s[k]  <= rem_nx[k];
				oor_s[k]  <= oor_in[k];
			end
		end
	end

	assign in_ready  = ready[0];
	assign out_valid = valid_s[LAST];
	assign out_res   = '{quo: work_s[LAST], rem: rem_s[LAST], oor: oor_s[LAST]};

`ifndef ASSERT_OFF
	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[LAST] && !out_ready |=> valid_s[LAST] && $stable(work_s[LAST])
			&& $stable(rem_s[LAST]))
		else $error("divider result changed while held");
`endif

endmodule

FILE: sv/sopr_remap.sv
module sopr_remap (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sopr_pkg::div_res_t                 in_res,
	input  logic [sopr_pkg::SIDE_W-1:0]        rows,
	input  logic [sopr_pkg::SIDE_W-1:0]        cols,
	input  logic [sopr_pkg::LAYOUT_W-1:0]      src_layout,
	input  logic [sopr_pkg::LAYOUT_W-1:0]      dst_layout,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sopr_pkg::MAP_W-1:0]         mapped_number,
	output logic                               out_of_range
);

	localparam int SW = sopr_pkg::SIDE_W;
	localparam int TW = sopr_pkg::TOTAL_W;
	localparam int MW = sopr_pkg::MAP_W;

	logic          valid_s1, valid_s2, valid_s3;
	logic [SW-1:0] row_s1, col_s1;
	logic          oor_s1, oor_s2, oor_s3;
	logic [TW-1:0] sum_s2, total_s2;
	logic [MW-1:0] mapped_s3;
	logic          rdy1, rdy2, rdy3;

	logic [SW-1:0] row_c, col_c;
	logic [SW-1:0] mul_a, mul_b, addend;
	logic [TW-1:0] sum_c, total_c, res_c;

	logic src_cm, dst_cm;

	assign src_cm = sopr_pkg::layout_col_major(src_layout);
	assign dst_cm = sopr_pkg::layout_col_major(dst_layout);

	assign rdy3     = !valid_s3 || !out_stall;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 1: split into row and column, undo the source ordering, apply the target
	// line reversal. A quotient above the line count only occurs out of range.
	always_comb begin
		if (src_cm) begin
			row_c = in_res.rem;
			col_c = in_res.quo[SW-1:0];
		end else begin
			row_c = in_res.quo[SW-1:0];
			col_c = in_res.rem;
		end
		if (sopr_pkg::layout_reversed(src_layout)) begin
			row_c = sopr_pkg::mirror(rows, row_c);
			col_c = sopr_pkg::mirror(cols, col_c);
		end
		if (src_cm) begin
			if (sopr_pkg::line_flipped(sopr_pkg::layout_kind(src_layout), col_c[0])) begin
				row_c = sopr_pkg::mirror(rows, row_c);
			end
		end else begin
			if (sopr_pkg::line_flipped(sopr_pkg::layout_kind(src_layout), row_c[0])) begin
				col_c = sopr_pkg::mirror(cols, col_c);
			end
		end
		if (dst_cm) begin
			if (sopr_pkg::line_flipped(sopr_pkg::layout_kind(dst_layout), col_c[0])) begin
				row_c = sopr_pkg::mirror(rows, row_c);
			end
		end else begin
			if (sopr_pkg::line_flipped(sopr_pkg::layout_kind(dst_layout), row_c[0])) begin
				col_c = sopr_pkg::mirror(cols, col_c);
			end
		end
	end

	// Stage 2: recombine into a 1-based number.
	assign mul_a   = dst_cm ? col_s1 : row_s1;
	assign mul_b   = dst_cm ? rows : cols;
	assign addend  = dst_cm ? row_s1 : col_s1;
	assign sum_c   = TW'(mul_a) * TW'(mul_b) + TW'(addend) + TW'(1);
	assign total_c = TW'(rows) * TW'(cols);

	// Stage 3: mirror over the whole grid for a reversed target order.
	assign res_c = sopr_pkg::layout_reversed(dst_layout) ?
		(total_s2 - sum_s2 + TW'(1)) : sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			row_s1 <= row_c;
			col_s1 <= col_c;
			oor_s1 <= in_res.oor;
		end
		if (rdy2 && valid_s1) begin
			sum_s2   <= sum_c;
			total_s2 <= total_c;
			oor_s2   <= oor_s1;
		end
		if (rdy3 && valid_s2) begin
			mapped_s3 <= oor_s2 ? '0 : res_c[MW-1:0];
			oor_s3    <= oor_s2;
		end
	end

	assign out_valid     = valid_s3;
	assign mapped_number = mapped_s3;
	assign out_of_range  = oor_s3;

`ifndef ASSERT_OFF
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> mapped_number == '0)
		else $error("out-of-range result carries a nonzero number");
`endif

endmodule

FILE: sv/scan_order_position_remap.sv
// Scan order position remap.
// Input channel (in_valid / in_stall / cell_number) takes a 1-based cell number
// in the source layout; output channel (out_valid / out_stall / mapped_number,
// out_of_range) returns the same cell's number in the target layout, one result
// per transaction, in order. A number of zero or beyond rows times columns
// returns out_of_range with mapped_number zero.
// Configuration is a write port (cfg_wr_en, cfg_index, cfg_data): rows, columns,
// source layout, target layout. Sides above 256 saturate. Write only while the
// pipeline is empty.
// The pipeline has 8 register stages: a range check stage, four divider stages
// resolving four quotient bits each, and three remap stages.
// Throughput is one transaction per cycle while out_stall is low.
// Reset empties the pipeline and sets a 1 x 1 grid with both layouts plain.
// A stall on the output holds the last stage; bubbles in the pipeline still
// close up, and in_stall rises only once every stage holds a transaction.
module scan_order_position_remap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sopr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sopr_pkg::SIDE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sopr_pkg::NUM_W-1:0]          cell_number,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sopr_pkg::MAP_W-1:0]          mapped_number,
	output logic                                out_of_range
);

	localparam int SW = sopr_pkg::SIDE_W;
	localparam int TW = sopr_pkg::TOTAL_W;
	localparam int NW = sopr_pkg::NUM_W;
	localparam int LW = sopr_pkg::LAYOUT_W;

	logic [SW-1:0] rows_q, cols_q;
	logic [LW-1:0] src_q, dst_q;

	logic          valid_s1;
	logic [NW-1:0] offset_s1;
	logic          oor_s1;
	logic          ready_s1;
	logic [TW-1:0] total_c;
	logic          oor_c;

	logic                div_in_ready, div_out_valid, div_out_ready;
	sopr_pkg::div_res_t  div_res;
	logic [SW-1:0]       divisor;

	function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v);
		return (32'(v) > 32'(sopr_pkg::MAX_SIDE)) ? SW'(sopr_pkg::MAX_SIDE) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SW'(1);
			cols_q <= SW'(1);
			src_q  <= '0;
			dst_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (sopr_pkg::cfg_idx_t'(cfg_index))
				sopr_pkg::CFG_ROWS: rows_q <= clamp_side(cfg_data);
				sopr_pkg::CFG_COLS: cols_q <= clamp_side(cfg_data);
				sopr_pkg::CFG_SRC:  src_q  <= cfg_data[LW-1:0];
				sopr_pkg::CFG_DST:  dst_q  <= cfg_data[LW-1:0];
			endcase
		end
	end

	// Range check stage. A zero side gives a zero total, so everything is out of range.
	assign total_c  = TW'(rows_q) * TW'(cols_q);
	assign oor_c    = (cell_number == '0) || (TW'(cell_number) > total_c);
	assign ready_s1 = !valid_s1 || div_in_ready;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			offset_s1 <= cell_number - NW'(1);
			oor_s1    <= oor_c;
		end
	end

	assign divisor = sopr_pkg::layout_col_major(src_q) ? rows_q : cols_q;

	sopr_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (div_in_ready),
		.in_req    ('{offset: offset_s1, oor: oor_s1}),
		.divisor   (divisor),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_res   (div_res)
	);

	sopr_remap u_remap (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (div_out_valid),
		.in_ready      (div_out_ready),
		.in_res        (div_res),
		.rows          (rows_q),
		.cols          (cols_q),
		.src_layout    (src_q),
		.dst_layout    (dst_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mapped_number (mapped_number),
		.out_of_range  (out_of_range)
	);

`ifndef ASSERT_OFF
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transaction did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(offset_s1) && $stable(oor_s1))
		else $error("first stage lost its transaction under stall");
`endif

endmodule
